// ----- src/hmd_pkg.sv -----
// ----------------------------------------------------------------------------
// hmd_pkg
// Shared types, command and status codes, and the hash and decimal
// conversion steps for the hashed mount directory.
// ----------------------------------------------------------------------------
package hmd_pkg;

  localparam int DATA_W = 64;

  localparam logic [DATA_W-1:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [8:0]        PRIME_LOW  = 9'h1b3;  // prime is 2^40 + 0x1b3
  localparam logic [7:0]        ASCII_ZERO = 8'h30;

  // A 64-bit pid has at most 20 decimal digits.
  localparam int PID_DIGITS    = 20;
  localparam int BCD_W         = 4 * PID_DIGITS;
  localparam int BCD_STEP_BITS = 4;

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_RMOUNT = 2'd2;
  localparam logic [1:0] FN_RPROC  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_PID_TAKEN  = 2'd2;
  localparam logic [1:0] ST_NAME_TAKEN = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [7:0]        name_byte;
    logic              byte_valid;
    logic              name_last;
    logic [DATA_W-1:0] proc_id;
  } hmd_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] found_pid;
  } hmd_out_t;

  // One hash step: multiply by the prime, then xor in the character.
  function automatic logic [DATA_W-1:0] fnv_step(input logic [DATA_W-1:0] h,
                                                 input logic [7:0] c);
    logic [DATA_W-1:0] prod;
    prod = (h << 40) + (h * {{(DATA_W-9){1'b0}}, PRIME_LOW});
    return prod ^ {{(DATA_W-8){1'b0}}, c};
  endfunction

  // One double-dabble step: correct each digit above four, then shift in
  // the next binary bit.
  function automatic logic [BCD_W-1:0] bcd_shift(input logic [BCD_W-1:0] b,
                                                 input logic bin);
    logic [BCD_W-1:0] adj;
    for (int k = 0; k < PID_DIGITS; k++) begin
      adj[4*k +: 4] = (b[4*k +: 4] >= 4'd5) ? b[4*k +: 4] + 4'd3 : b[4*k +: 4];
    end
    return {adj[BCD_W-2:0], bin};
  endfunction

endpackage

// ----- src/hmd_divu.sv -----
// ----------------------------------------------------------------------------
// hmd_divu
// Remainder of a 64-bit value by a constant modulus, each step registered:
// byte residue folding, a reciprocal multiply and one correcting subtraction.
// ----------------------------------------------------------------------------
module hmd_divu #(
  parameter int MODULUS = 1023,
  parameter int RW      = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hmd_pkg::DATA_W-1:0] dividend,
  output logic                       done,
  output logic [RW-1:0]              rem
);
  import hmd_pkg::*;

  // The modulus is below 2^17, so eight folded bytes stay below 2^28.
  localparam int KW = 17;
  localparam int SW = 28;
  localparam logic [63:0] MOD64 = 64'(MODULUS);

  // Residues of 2^(8*i) for each dividend byte.
  localparam logic [8*KW-1:0] RES = {
    KW'((64'd1 << 56) % MOD64), KW'((64'd1 << 48) % MOD64),
    KW'((64'd1 << 40) % MOD64), KW'((64'd1 << 32) % MOD64),
    KW'((64'd1 << 24) % MOD64), KW'((64'd1 << 16) % MOD64),
    KW'((64'd1 << 8) % MOD64),  KW'(64'd1 % MOD64)
  };
  localparam logic [SW-1:0] RECIP = SW'((64'd1 << SW) / MOD64);

  logic [2:0]      stg_r;
  logic [SW-1:0]   sum_r, q_r;
  logic [RW-1:0]   rem_r;
  logic [SW-1:0]   fold, diff;
  logic [2*SW-1:0] prod;

  always_comb begin
    fold = '0;
    for (int i = 0; i < 8; i++) begin
      fold = fold + SW'(dividend[8*i +: 8]) * SW'(RES[i*KW +: KW]);
    end
  end

  // The estimated quotient is exact or one low, so one subtraction corrects it.
  assign prod = {{SW{1'b0}}, sum_r} * {{SW{1'b0}}, RECIP};
  assign diff = sum_r - q_r * SW'(MODULUS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= fold;
    end
    if (stg_r[0]) begin
      q_r <= prod[2*SW-1:SW];
    end
    if (stg_r[1]) begin
      rem_r <= (diff >= SW'(MODULUS)) ? RW'(diff - SW'(MODULUS)) : RW'(diff);
    end
  end

  assign done = stg_r[2];
  assign rem  = rem_r;

endmodule

// ----- src/hmd_ram.sv -----
// ----------------------------------------------------------------------------
// hmd_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module hmd_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 1023
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/hashed_mount_directory.sv -----
// ----------------------------------------------------------------------------
// hashed_mount_directory
// Direct-mapped name to pid directory with a reverse pid to name-slot table.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  in      | in_valid, in_ready, in_data  | hmd_in_t  (command, name byte, pid)
//  out     | out_valid, out_ready, out_data | hmd_out_t (status, found pid)
//
// After reset both tables are cleared, one entry per cycle.
// A name byte without the last marker only updates the running name hash.
// A final transaction first reduces the name hash modulo TABLE_LEN. A
// lookup then reads the tables; a zero pid ends other commands as not
// found; otherwise the pid is converted to decimal, its digits are hashed
// and reduced, and the tables are read; remove process may read a second time.
// A finished result waits in the output register while out_ready is low.
// ----------------------------------------------------------------------------
module hashed_mount_directory #(
  parameter int TABLE_LEN = 1023
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hmd_pkg::hmd_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hmd_pkg::hmd_out_t out_data
);
  import hmd_pkg::*;

  localparam int IDX_W      = $clog2(TABLE_LEN);
  localparam int BCD_CYCLES = DATA_W / BCD_STEP_BITS;
  localparam int BCW        = $clog2(BCD_CYCLES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NMOD, S_NWAIT, S_BCD, S_DIG, S_PMOD, S_PWAIT,
    S_RD1, S_EVAL1, S_RD2, S_EVAL2, S_DONE
  } state_t;

  state_t            state_r;
  logic [DATA_W-1:0] acc_r, hash_r, pid_r, v_r, h_r, found_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [BCW-1:0]    cnt_r;
  logic [1:0]        func_r, status_r;
  logic [IDX_W-1:0]  nidx_r, pidx_r, stored_r, clr_r;
  logic              out_valid_r;
  hmd_out_t          out_data_r;

  logic [DATA_W-1:0] acc_upd;
  logic [BCD_W-1:0]  bcd_upd;
  logic              in_acc;

  logic              m_done;
  logic [DATA_W-1:0] m_dividend;
  logic [IDX_W-1:0]  m_rem;

  logic [IDX_W-1:0]  nm_addr, pm_addr, pm_wdata;
  logic              nm_we, pm_we;
  logic [DATA_W-1:0] nm_wdata, nm_rdata;
  logic [IDX_W-1:0]  pm_rdata;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign acc_upd  = in_data.byte_valid ? fnv_step(acc_r, in_data.name_byte) : acc_r;

  assign m_dividend = (state_r == S_PMOD) ? h_r : hash_r;

  hmd_divu #(.MODULUS(TABLE_LEN), .RW(IDX_W)) u_mod (
    .clk(clk), .rst_n(rst_n),
    .start((state_r == S_NMOD) || (state_r == S_PMOD)),
    .dividend(m_dividend), .done(m_done), .rem(m_rem)
  );

  // Binary to decimal conversion of the pid, four bits per cycle.
  always_comb begin
    bcd_upd = bcd_r;
    for (int k = 0; k < BCD_STEP_BITS; k++) begin
      bcd_upd = bcd_shift(bcd_upd, v_r[DATA_W-1-k]);
    end
  end

  hmd_ram #(.W(DATA_W), .DEPTH(TABLE_LEN)) u_name_ram (
    .clk(clk), .addr(nm_addr), .we(nm_we), .wdata(nm_wdata), .rdata(nm_rdata)
  );

  hmd_ram #(.W(IDX_W), .DEPTH(TABLE_LEN)) u_pid_ram (
    .clk(clk), .addr(pm_addr), .we(pm_we), .wdata(pm_wdata), .rdata(pm_rdata)
  );

  // Table addressing and write-back decisions.
  always_comb begin
    nm_addr  = nidx_r;
    pm_addr  = pidx_r;
    nm_we    = 1'b0;
    pm_we    = 1'b0;
    nm_wdata = '0;
    pm_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        nm_addr = clr_r;
        pm_addr = clr_r;
        nm_we   = 1'b1;
        pm_we   = 1'b1;
      end
      S_EVAL1: begin
        case (func_r)
          FN_ADD: begin
            if (pm_rdata == '0 && nm_rdata == '0) begin
              nm_we    = 1'b1;
              pm_we    = 1'b1;
              nm_wdata = pid_r;
              pm_wdata = nidx_r;
            end
          end
          FN_RMOUNT: begin
            if (pm_rdata != '0 && nm_rdata == pid_r) begin
              nm_we = 1'b1;
              pm_we = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_RD2: nm_addr = stored_r;
      S_EVAL2: begin
        nm_addr = stored_r;
        if (nm_rdata == pid_r) begin
          nm_we = 1'b1;
          pm_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      acc_r       <= HASH_BASIS;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == IDX_W'(TABLE_LEN - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.name_last) begin
              acc_r   <= HASH_BASIS;
              hash_r  <= acc_upd;
              func_r  <= in_data.func;
              pid_r   <= in_data.proc_id;
              found_r <= '0;
              state_r <= S_NMOD;
            end else begin
              acc_r <= acc_upd;
            end
          end
        end
        S_NMOD: state_r <= S_NWAIT;
        S_NWAIT: begin
          if (m_done) begin
            nidx_r <= m_rem;
            v_r    <= pid_r;
            h_r    <= HASH_BASIS;
            bcd_r  <= '0;
            cnt_r  <= '0;
            if (func_r == FN_LOOKUP) begin
              state_r <= S_RD1;
            end else if (pid_r == '0) begin
              status_r <= ST_NOT_FOUND;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_BCD;
            end
          end
        end
        S_BCD: begin
          bcd_r <= bcd_upd;
          v_r   <= v_r << BCD_STEP_BITS;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == BCW'(BCD_CYCLES - 1)) begin
            state_r <= S_DIG;
          end
        end
        // Digits are hashed least significant first, up to the highest
        // nonzero one.
        S_DIG: begin
          h_r     <= fnv_step(h_r, ASCII_ZERO + {4'd0, bcd_r[3:0]});
          bcd_r   <= bcd_r >> 4;
          state_r <= (bcd_r[BCD_W-1:4] == '0) ? S_PMOD : S_DIG;
        end
        S_PMOD: state_r <= S_PWAIT;
        S_PWAIT: begin
          if (m_done) begin
            pidx_r  <= m_rem;
            state_r <= S_RD1;
          end
        end
        S_RD1: state_r <= S_EVAL1;
        S_EVAL1: begin
          state_r <= S_DONE;
          case (func_r)
            FN_LOOKUP: begin
              if (nm_rdata != '0) begin
                status_r <= ST_OK;
                found_r  <= nm_rdata;
              end else begin
                status_r <= ST_NOT_FOUND;
              end
            end
            FN_ADD: begin
              if (pm_rdata != '0) begin
                status_r <= ST_PID_TAKEN;
              end else if (nm_rdata != '0) begin
                status_r <= ST_NAME_TAKEN;
              end else begin
                status_r <= ST_OK;
              end
            end
            FN_RMOUNT: begin
              status_r <= (pm_rdata != '0 && nm_rdata == pid_r) ? ST_OK : ST_NOT_FOUND;
            end
            default: begin
              if (pm_rdata == '0 || {1'b0, pm_rdata} >= (IDX_W+1)'(TABLE_LEN)) begin
                status_r <= ST_NOT_FOUND;
              end else begin
                stored_r <= pm_rdata;
                state_r  <= S_RD2;
              end
            end
          endcase
        end
        S_RD2: state_r <= S_EVAL2;
        S_EVAL2: begin
          status_r <= (nm_rdata == pid_r) ? ST_OK : ST_NOT_FOUND;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_data_r.status    <= status_r;
            out_data_r.found_pid <= found_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A final transaction closes the input until its result is produced.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.name_last |=> !in_ready)
    else $error("input accepted while a command is in progress");

  // Only a successful lookup reports a pid.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found_pid != '0 |-> out_data.status == ST_OK)
    else $error("found pid with non-ok status");

  // Tables are never written while waiting for commands.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !nm_we && !pm_we)
    else $error("table write while idle");

  // No result appears during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_valid && !in_ready)
    else $error("channel active during table clear");

endmodule

// ----- bench/tb_hashed_mount_directory.sv -----
// ----------------------------------------------------------------------------
// tb_hashed_mount_directory
// Drives name/pid commands into the mount directory, predicts each status
// and found pid with a behavioral copy of both tables, and checks results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hashed_mount_directory;
  import hmd_pkg::*;

  localparam int TBL = 1023;
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  hmd_in_t in_data;
  logic out_valid;
  logic out_ready;
  hmd_out_t out_data;

  hashed_mount_directory #(.TABLE_LEN(TBL)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted directory state.
  logic [63:0] mdl_hash;
  logic [63:0] mdl_names [TBL];
  logic [31:0] mdl_pids [TBL];
  hmd_out_t pending_results [$];
  int errors;
  int idle_cycles;
  int burst_left;
  logic [63:0] pid_pool [8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] hash_mul(input logic [63:0] h, input logic [7:0] c);
    logic [63:0] p;
    p = h * 64'h100000001b3;
    return p ^ {56'd0, c};
  endfunction

  function automatic logic [63:0] digit_hash(input logic [63:0] v);
    logic [63:0] h;
    h = 64'hcbf29ce484222325;
    while (v != 0) begin
      h = hash_mul(h, 8'(v % 10) + 8'h30);
      v = v / 10;
    end
    return h;
  endfunction

  function automatic hmd_out_t run_directory(input hmd_in_t it);
    hmd_out_t r;
    logic [63:0] nidx;
    logic [63:0] pidx;
    logic [31:0] stored;
    if (it.byte_valid) mdl_hash = hash_mul(mdl_hash, it.name_byte);
    r.status = ST_OK;
    r.found_pid = '0;
    nidx = mdl_hash % TBL;
    mdl_hash = 64'hcbf29ce484222325;
    if (it.func == FN_LOOKUP) begin
      if (mdl_names[nidx] != 0) r.found_pid = mdl_names[nidx];
      else r.status = ST_NOT_FOUND;
      return r;
    end
    if (it.proc_id == 0) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    pidx = digit_hash(it.proc_id) % TBL;
    if (it.func == FN_ADD) begin
      if (mdl_pids[pidx] != 0) r.status = ST_PID_TAKEN;
      else if (mdl_names[nidx] != 0) r.status = ST_NAME_TAKEN;
      else begin
        mdl_names[nidx] = it.proc_id;
        mdl_pids[pidx] = 32'(nidx);
      end
      return r;
    end
    if (mdl_pids[pidx] == 0) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    if (it.func == FN_RMOUNT) begin
      if (mdl_names[nidx] != it.proc_id) r.status = ST_NOT_FOUND;
      else begin
        mdl_names[nidx] = '0;
        mdl_pids[pidx] = '0;
      end
      return r;
    end
    stored = mdl_pids[pidx];
    if (stored >= TBL || mdl_names[stored] != it.proc_id) r.status = ST_NOT_FOUND;
    else begin
      mdl_names[stored] = '0;
      mdl_pids[pidx] = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // Sends one transaction, with bursty gaps between sends.
  task automatic send_item(input hmd_in_t it);
    hmd_out_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.name_last) begin
      r = run_directory(it);
      pending_results.push_back(r);
    end else if (it.byte_valid) begin
      mdl_hash = hash_mul(mdl_hash, it.name_byte);
    end
  endtask

  // Sends a whole command: name bytes, ending in a final transaction or byte.
  task automatic send_command(input logic [1:0] fn, input logic [63:0] pid,
                              input logic [7:0] name [$], input bit tail_byte);
    hmd_in_t it;
    int n;
    n = name.size();
    for (int i = 0; i < n; i++) begin
      it.func = 2'($urandom);
      it.name_byte = name[i];
      it.byte_valid = 1'b1;
      it.name_last = (i == n - 1) && tail_byte;
      it.proc_id = {$urandom, $urandom};
      if (it.name_last) begin
        it.func = fn;
        it.proc_id = pid;
      end
      send_item(it);
    end
    if (!tail_byte || n == 0) begin
      it.func = fn;
      it.name_byte = 8'($urandom);
      it.byte_valid = 1'b0;
      it.name_last = 1'b1;
      it.proc_id = pid;
      send_item(it);
    end
  endtask

  function automatic void rand_name(ref logic [7:0] nm [$], input int len);
    nm.delete();
    for (int i = 0; i < len; i++) nm.push_back(8'($urandom_range(1, 255)));
  endfunction

  task automatic test_directed();
    logic [7:0] nm [$];
    logic [7:0] nm2 [$];
    nm.delete();
    send_command(FN_LOOKUP, 64'd0, nm, 1'b0);
    send_command(FN_ADD, 64'd0, nm, 1'b0);
    send_command(FN_ADD, 64'hffff_ffff_ffff_ffff, nm, 1'b0);
    send_command(FN_LOOKUP, 64'd0, nm, 1'b0);
    send_command(FN_ADD, 64'd7, nm, 1'b0);
    nm = '{8'h01, 8'hff};
    send_command(FN_ADD, 64'hffff_ffff_ffff_ffff, nm, 1'b1);
    send_command(FN_ADD, 64'd12345, nm, 1'b1);
    send_command(FN_LOOKUP, 64'd0, nm, 1'b1);
    nm2 = '{8'h55, 8'haa, 8'h80};
    send_command(FN_RMOUNT, 64'd12345, nm2, 1'b0);
    send_command(FN_RMOUNT, 64'd12345, nm, 1'b0);
    send_command(FN_RMOUNT, 64'd0, nm, 1'b0);
    send_command(FN_RPROC, 64'hffff_ffff_ffff_ffff, nm2, 1'b1);
    send_command(FN_RPROC, 64'd1, nm2, 1'b1);
    send_command(FN_RPROC, 64'd0, nm2, 1'b0);
    nm.delete();
    send_command(FN_RMOUNT, 64'hffff_ffff_ffff_ffff, nm, 1'b0);
    send_command(FN_LOOKUP, 64'd0, nm, 1'b0);
  endtask

  task automatic test_random(input int items);
    logic [7:0] nm [$];
    logic [63:0] pid;
    int sent;
    bit tail;
    sent = 0;
    for (int i = 0; i < 8; i++)
      pid_pool[i] = ($urandom_range(0, 1) == 0) ? 64'($urandom_range(1, 99999))
                                                 : {$urandom, $urandom};
    while (sent < items) begin
      // Short names from a small alphabet so that adds, lookups and removes meet.
      nm.delete();
      for (int i = 0; i < $urandom_range(0, 3); i++)
        nm.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(8'h61, 8'h64)));
      case ($urandom_range(0, 9))
        0: pid = 64'd0;
        1: pid = {$urandom, $urandom};
        default: pid = pid_pool[$urandom_range(0, 7)];
      endcase
      tail = 1'($urandom);
      send_command(2'($urandom), pid, nm, tail);
      sent += (tail && nm.size() != 0) ? nm.size() : nm.size() + 1;
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    hmd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.found_pid, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.found_pid !== want.found_pid)
          report_mismatch("found_pid", out_data.found_pid, want.found_pid);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    out_ready <= ($urandom_range(0, 15) < 4) ? 1'b0 : 1'b1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mdl_hash = 64'hcbf29ce484222325;
    for (int i = 0; i < TBL; i++) begin
      mdl_names[i] = '0;
      mdl_pids[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(1150);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1600) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/hmd_pkg.sv
src/hmd_divu.sv
src/hmd_ram.sv
src/hashed_mount_directory.sv
bench/tb_hashed_mount_directory.sv
